// ----- sv/lexicographic_combination_generator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LEXICOGRAPHIC_COMBINATION_GENERATOR_ASSERT_SVH
`define LEXICOGRAPHIC_COMBINATION_GENERATOR_ASSERT_SVH

// same-cycle implication
`define LCG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcg assertion failed");

// next-cycle implication
`define LCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcg assertion failed");

`endif

// ----- sv/lcg_pkg.sv -----
// ----------------------------------------------------------------------------
// lcg_pkg
// Widths, limits, register indexes and control types of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcg_pkg;

    localparam int MAX_CHOOSE = 8;
    localparam int MAX_SET    = 32;

    localparam int ELEM_W = 6;
    localparam int SET_W  = 6;
    localparam int K_W    = 4;
    localparam int POS_W  = $clog2(MAX_CHOOSE);
    localparam int MAX_W  = ELEM_W + 1;
    localparam int CFG_W  = 6;
    localparam int ADDR_W = 1;

    localparam logic [ADDR_W-1:0] CFG_SET_SIZE    = 1'b0;
    localparam logic [ADDR_W-1:0] CFG_CHOOSE_SIZE = 1'b1;

    typedef logic [ELEM_W-1:0] t_elem;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_CHECK,
        ST_EMIT,
        ST_EXH
    } t_state;

    typedef struct packed {
        logic             load_first;
        logic             advance;
        logic             set_finished;
        logic             check;
        logic             emit_elem;
        logic             emit_exh;
        logic [POS_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic started;
        logic finished;
        logic can_advance;
        logic pos_last;
        logic slot_free;
    } t_status;

endpackage

// ----- sv/lcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcg_ctrl
// Sequencer: decodes each request, steps the datapath and serialises output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_ctrl
    import lcg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  logic    i_restart,
    output logic    o_req_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.pos   = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    priority if (!i_status.valid) begin
                        n_state = ST_EXH;
                    end else if (i_restart) begin
                        o_cmd.load_first = 1'b1;
                        n_state          = ST_CHECK;
                    end else if (!i_status.started || i_status.finished) begin
                        n_state = ST_EXH;
                    end else if (!i_status.can_advance) begin
                        o_cmd.set_finished = 1'b1;
                        n_state            = ST_EXH;
                    end else begin
                        n_state = ST_ADV;
                    end
                end
            end
            ST_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_pos       = '0;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_elem = 1'b1;
                    if (i_status.pos_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            ST_EXH: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_exh = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- sv/lcg_dpath.sv -----
// ----------------------------------------------------------------------------
// lcg_dpath
// Settings, combination store, successor logic and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_dpath
    import lcg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_elem             o_element,
    output logic [POS_W-1:0]  o_position,
    output logic              o_last,
    output logic              o_final,
    output logic              o_exhausted
);

    logic [SET_W-1:0] r_set_size;
    logic [K_W-1:0]   r_choose_size;
    t_elem            r_store [MAX_CHOOSE];
    logic             r_started;
    logic             r_finished;

    logic             r_out_valid;
    t_elem            r_out_element;
    logic [POS_W-1:0] r_out_position;
    logic             r_out_last;
    logic             r_out_final;
    logic             r_out_exh;

    logic [MAX_CHOOSE-1:0] w_in_k;
    logic [MAX_CHOOSE-1:0] w_below;
    logic [MAX_CHOOSE-1:0] w_pivot;
    t_elem                 w_next [MAX_CHOOSE];
    t_elem                 w_base;
    logic [MAX_W-1:0]      w_max;
    logic                  w_seen;
    logic                  w_run;
    logic                  w_valid;
    logic                  w_pos_last;
    logic                  w_slot_free;

    always_comb begin
        w_valid = (r_set_size >= SET_W'(1)) && (r_choose_size >= K_W'(1))
               && (r_choose_size <= K_W'(MAX_CHOOSE)) && (r_set_size <= SET_W'(MAX_SET))
               && (SET_W'(r_choose_size) <= r_set_size);
    end

    // position j is below its maximum n-k+j+1
    always_comb begin
        for (int j = 0; j < MAX_CHOOSE; j++) begin
            w_max      = MAX_W'(r_set_size) - MAX_W'(r_choose_size) + MAX_W'(j + 1);
            w_in_k[j]  = K_W'(j) < r_choose_size;
            w_below[j] = w_in_k[j] && (MAX_W'(r_store[j]) < w_max);
        end
    end

    // rightmost element that can still move, then the ascending run after it
    // (pivot value + 1 - pivot index, plus the position, modulo the width)
    always_comb begin
        w_seen = 1'b0;
        for (int j = MAX_CHOOSE - 1; j >= 0; j--) begin
            w_pivot[j] = w_below[j] && !w_seen;
            w_seen     = w_seen || w_below[j];
        end
        w_run  = 1'b0;
        w_base = '0;
        for (int j = 0; j < MAX_CHOOSE; j++) begin
            if (w_pivot[j]) begin
                w_base = r_store[j] + ELEM_W'(1) - ELEM_W'(j);
                w_run  = 1'b1;
            end
            if (w_run && w_in_k[j]) begin
                w_next[j] = w_base + ELEM_W'(j);
            end else begin
                w_next[j] = r_store[j];
            end
        end
    end

    assign w_pos_last  = K_W'(i_cmd.pos) == (r_choose_size - K_W'(1));
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.valid       = w_valid;
        o_status.started     = r_started;
        o_status.finished    = r_finished;
        o_status.can_advance = |w_below;
        o_status.pos_last    = w_pos_last;
        o_status.slot_free   = w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size    <= SET_W'(1);
            r_choose_size <= K_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SET_SIZE:    r_set_size    <= i_cfg_wdata[SET_W-1:0];
                CFG_CHOOSE_SIZE: r_choose_size <= i_cfg_wdata[K_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_CHOOSE; j++) begin
                r_store[j] <= '0;
            end
            r_started  <= 1'b0;
            r_finished <= 1'b0;
        end else begin
            if (i_cmd.load_first) begin
                for (int j = 0; j < MAX_CHOOSE; j++) begin
                    if (w_in_k[j]) begin
                        r_store[j] <= ELEM_W'(j + 1);
                    end
                end
                r_started <= 1'b1;
            end
            if (i_cmd.advance) begin
                for (int j = 0; j < MAX_CHOOSE; j++) begin
                    r_store[j] <= w_next[j];
                end
            end
            if (i_cmd.check) begin
                r_finished <= ~|w_below;
            end
            if (i_cmd.set_finished) begin
                r_finished <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_elem || i_cmd.emit_exh) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_elem) begin
            r_out_element  <= r_store[i_cmd.pos];
            r_out_position <= i_cmd.pos;
            r_out_last     <= w_pos_last;
            r_out_final    <= r_finished;
            r_out_exh      <= 1'b0;
        end else if (i_cmd.emit_exh) begin
            r_out_element  <= '0;
            r_out_position <= '0;
            r_out_last     <= 1'b1;
            r_out_final    <= 1'b0;
            r_out_exh      <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_element   = r_out_element;
    assign o_position  = r_out_position;
    assign o_last      = r_out_last;
    assign o_final     = r_out_final;
    assign o_exhausted = r_out_exh;

endmodule

// ----- sv/lexicographic_combination_generator.sv -----
// ----------------------------------------------------------------------------
// lexicographic_combination_generator
// Walks the k-subsets of {1..n} in lexicographic order, one per request.
//
//   Channel   Dir  Handshake              Payload
//   s_axis    in   tvalid/tready          tdata[0] restart
//   m_axis    out  tvalid/tready          tdata element, position; tlast; tuser
//   cfg       in   i_cfg_we               i_cfg_addr, i_cfg_wdata
//
// An advance request passes through decode, successor and finished check,
// then sends its elements one by one through the output register; a restart
// skips the successor step; an exhausted result is emitted straight after decode.
// One request is in flight at a time.
// Reset: n = k = 1, store cleared, no combination started.
// Output stalls hold the element sequencer; a new request is taken while the
// last result of the previous one still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lexicographic_combination_generator
    import lcg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [0] restart
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [5:0] element, [8:6] position
    output logic              m_axis_tlast,
    output logic [1:0]        m_axis_tuser    // [0] final_combination, [1] exhausted
);

    t_cmd             w_cmd;
    t_status          w_status;
    t_elem            w_element;
    logic [POS_W-1:0] w_position;
    logic             w_final;
    logic             w_exhausted;

    lcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_restart   (s_axis_tdata[0]),
        .o_req_ready (s_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lcg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_element   (w_element),
        .o_position  (w_position),
        .o_last      (m_axis_tlast),
        .o_final     (w_final),
        .o_exhausted (w_exhausted)
    );

    assign m_axis_tdata = {(16 - ELEM_W - POS_W)'(0), w_position, w_element};
    assign m_axis_tuser = {w_exhausted, w_final};

`include "lexicographic_combination_generator_assert.svh"

    `LCG_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LCG_ASSERT_NOW(a_exh_single, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && ~|m_axis_tdata[8:0])
    `LCG_ASSERT_NOW(a_exh_not_final, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Combination generator testbench
// Walks a table of directed requests, then random runs of restart/advance
// requests under changing set and choose sizes. Results are checked against an
// in-bench successor predictor, or the table for typed rows. Both stream sides
// idle at random; the receiver holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import lcg_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 106;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [2:0]        position;
        logic              last_elem;
        logic              final_comb;
        logic              exhausted;
    } t_elem_res;

    typedef struct packed {
        logic      cfg;
        logic [5:0] n;
        logic [5:0] k;
        logic      restart;
        logic      typed;
        t_elem_res res;
    } t_row;

    localparam t_elem_res EXH    = '{'0, '0, 1'b1, 1'b0, 1'b1};
    localparam t_elem_res NO_RES = '0;

    localparam int N_ROWS = 24;
    localparam t_row STIMULUS [N_ROWS] = '{
        // reset settings n = k = 1: advance before any restart
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b1, EXH},
        '{1'b0, 6'd0,  6'd0,  1'b1, 1'b1, '{6'd1, 3'd0, 1'b1, 1'b1, 1'b0}},
        // advance past the final combination
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b1, EXH},
        // set size zero
        '{1'b1, 6'd0,  6'd1,  1'b1, 1'b1, EXH},
        '{1'b1, 6'd32, 6'd8,  1'b1, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        // shrink the set mid-run
        '{1'b1, 6'd8,  6'd8,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b1, 1'b0, NO_RES},
        // choose size above the maximum, zero, set size above the maximum
        '{1'b1, 6'd8,  6'd9,  1'b1, 1'b1, EXH},
        '{1'b1, 6'd8,  6'd0,  1'b0, 1'b1, EXH},
        '{1'b1, 6'd63, 6'd15, 1'b1, 1'b1, EXH},
        // choose size above set size
        '{1'b1, 6'd5,  6'd6,  1'b1, 1'b1, EXH},
        // full walk of 3 from 5
        '{1'b1, 6'd5,  6'd3,  1'b1, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b0, NO_RES},
        '{1'b0, 6'd0,  6'd0,  1'b0, 1'b1, EXH},
        '{1'b1, 6'd32, 6'd1,  1'b1, 1'b1, '{6'd1, 3'd0, 1'b1, 1'b0, 1'b0}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;
    logic              m_axis_tlast;
    logic [1:0]        m_axis_tuser;

    lexicographic_combination_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    int          cfg_n;
    int          cfg_k;
    logic [5:0]  comb_store [MAX_CHOOSE];
    bit          comb_started;
    bit          comb_finished;
    t_elem_res   awaited_elements [$];

    int          mismatches = 0;
    int          cycles     = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          rx_hold    = 1'b0;

    function automatic void queue_result(input t_elem_res r);
        awaited_elements.insert(awaited_elements.size(), r);
    endfunction

    function automatic bit at_last_combination();
        for (int i = 0; i < cfg_k; i++) begin
            if (int'(comb_store[i]) < cfg_n - cfg_k + i + 1) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void queue_combination();
        for (int i = 0; i < cfg_k; i++) begin
            queue_result('{comb_store[i], 3'(i), i + 1 == cfg_k, comb_finished, 1'b0});
        end
    endfunction

    function automatic void next_combination(input logic restart);
        int i;
        if (cfg_n < 1 || cfg_k < 1 || cfg_k > MAX_CHOOSE || cfg_n > MAX_SET ||
            cfg_k > cfg_n) begin
            queue_result(EXH);
            return;
        end
        if (restart) begin
            for (i = 0; i < cfg_k; i++) comb_store[i] = 6'(i + 1);
            comb_started  = 1'b1;
            comb_finished = at_last_combination();
            queue_combination();
            return;
        end
        if (!comb_started || comb_finished) begin
            queue_result(EXH);
            return;
        end
        i = cfg_k;
        while (i > 0 && int'(comb_store[i-1]) >= cfg_n - cfg_k + i) i--;
        if (i == 0) begin
            comb_finished = 1'b1;
            queue_result(EXH);
            return;
        end
        i--;
        comb_store[i] = comb_store[i] + 6'd1;
        for (int j = i + 1; j < cfg_k; j++) comb_store[j] = comb_store[i] + 6'(j - i);
        comb_finished = at_last_combination();
        queue_combination();
    endfunction

    task automatic send_request(input logic restart, input logic typed,
                                input t_elem_res res);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        next_combination(restart);
        if (typed) begin
            void'(awaited_elements.pop_back());
            queue_result(res);
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_elements.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input logic [5:0] n, input logic [5:0] k);
        wait_for_results();
        write_reg(CFG_SET_SIZE, n);
        write_reg(CFG_CHOOSE_SIZE, k);
        cfg_n = int'(n);
        cfg_k = int'(k[3:0]);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_elem_res got;
        t_elem_res want;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[5:0], m_axis_tdata[8:6], m_axis_tlast,
                    m_axis_tuser[0], m_axis_tuser[1]};
            if (awaited_elements.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result elem %0d pos %0d last %0b fin %0b exh %0b",
                         $time, got.element, got.position, got.last_elem,
                         got.final_comb, got.exhausted);
            end else begin
                want = awaited_elements.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: expected elem %0d pos %0d last %0b fin %0b exh %0b",
                             $time, want.element, want.position, want.last_elem,
                             want.final_comb, want.exhausted);
                    $display("%0t:      got elem %0d pos %0d last %0b fin %0b exh %0b",
                             $time, got.element, got.position, got.last_elem,
                             got.final_comb, got.exhausted);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 13) : 0;
            if (rx_hold) begin
                rx_hold = 1'b0;
                stall   = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int         sent;
        int         phase;
        int         count;
        int         sel;
        logic [5:0] n;
        logic [5:0] k;
        logic       restart;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_n         = 1;
        cfg_k         = 1;
        comb_started  = 1'b0;
        comb_finished = 1'b0;
        for (int i = 0; i < MAX_CHOOSE; i++) comb_store[i] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if (STIMULUS[r].cfg) apply_settings(STIMULUS[r].n, STIMULUS[r].k);
            send_request(STIMULUS[r].restart, STIMULUS[r].typed, STIMULUS[r].res);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    n = 6'($urandom_range(0, 63));
                    k = 6'($urandom_range(0, 63));
                end
                1: begin
                    n = 6'd32;
                    k = 6'($urandom_range(1, 8));
                end
                2: begin
                    n = 6'd32;
                    k = 6'd1;
                end
                default: begin
                    n = 6'($urandom_range(1, 7));
                    k = 6'($urandom_range(1, n));
                end
            endcase
            apply_settings(n, k);
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            if (phase == 3) rx_hold = 1'b1;
            count = (sel == 2) ? 34 : $urandom_range(4, 24);
            if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
            for (int i = 0; i < count; i++) begin
                // first request of a phase sometimes carries on from the old store
                if (sel == 2) restart = (i == 0);
                else if (i == 0) restart = $urandom_range(0, 3) != 0;
                else restart = $urandom_range(0, 11) == 0;
                send_request(restart, 1'b0, NO_RES);
                sent++;
            end
            phase++;
        end

        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && awaited_elements.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
